// ----- hdl/cvm_pkg.sv -----
// shared types, constants and curve tables for the controller value mapper
package cvm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TBL_N     = 256;
  localparam int IDX_W     = $clog2(TBL_N);
  localparam int X_W       = FRAC_BITS + 1;
  localparam int VAL_W     = 24;
  localparam int RAW_W     = 14;
  localparam int CFG_W     = 24;
  localparam int DVD_W     = RAW_W + FRAC_BITS;
  localparam int MUL_A_W   = VAL_W + 1;
  localparam int MUL_B_W   = X_W + 2;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [X_W-1:0] ONE_X = X_W'(1) << FRAC_BITS;
  localparam logic [RAW_W-1:0] DEFAULT_SCALE = RAW_W'(127);

  // binding modes
  localparam logic [2:0] MODE_ABS    = 3'd0;
  localparam logic [2:0] MODE_TWOS   = 3'd1;
  localparam logic [2:0] MODE_SIGNMAG = 3'd2;
  localparam logic [2:0] MODE_OFFSET = 3'd3;
  localparam logic [2:0] MODE_TOGGLE = 3'd4;

  // curve shapes
  localparam logic [1:0] CURVE_LIN    = 2'd0;
  localparam logic [1:0] CURVE_LOG    = 2'd1;
  localparam logic [1:0] CURVE_EXP    = 2'd2;
  localparam logic [1:0] CURVE_SMOOTH = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_CURVE = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_LOW   = 3'd3;
  localparam logic [2:0] REG_HIGH  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SH1, ST_SH2, ST_SH3, ST_RG1, ST_RG2, ST_OUT
  } cvm_state_t;

  typedef logic [X_W-1:0] curve_tbl_t [0:TBL_N];
  typedef logic [X_W-1:0] sm_tbl_t [0:63];

  // unsigned long division by shift and subtract, for table building only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // q30 fraction rounded into the output format and capped at one
  function automatic logic [X_W-1:0] q30_to_frac(input longint unsigned q);
    longint unsigned r;
    r = (q * (64'd1 << FRAC_BITS) + (64'd1 << 29)) >> 30;
    if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
    return X_W'(r);
  endfunction

  // curve samples by integer series, evaluated at elaboration
  function automatic curve_tbl_t build_tbl(input bit is_log);
    curve_tbl_t t;
    longint unsigned u, term, sum, z, w, w2, p, s;
    longint unsigned q30one, em1;
    q30one = 64'd1 << 30;
    em1    = 64'd1844991065;
    for (int i = 0; i <= TBL_N; i++) begin
      u = (longint'(i) << 30) >> IDX_W;
      if (is_log) begin
        z  = q30one + ((u * em1) >> 30);
        w  = udiv64((z - q30one) << 30, z + q30one);
        w2 = (w * w) >> 30;
        p  = w;
        s  = 0;
        for (int k = 0; k < 40; k++) begin
          s = s + udiv64(p, longint'(2 * k + 1));
          p = (p * w2) >> 30;
        end
        t[i] = q30_to_frac(2 * s);
      end else begin
        term = q30one;
        sum  = q30one;
        for (int k = 1; k <= 24; k++) begin
          term = udiv64((term * u) >> 30, longint'(k));
          sum  = sum + term;
        end
        t[i] = q30_to_frac(udiv64((sum - q30one) << 30, em1));
      end
    end
    return t;
  endfunction

  // sign-magnitude step sizes, rounded
  function automatic sm_tbl_t build_sm();
    sm_tbl_t t;
    for (int m = 0; m < 64; m++) begin
      t[m] = X_W'(udiv64(longint'(m) * (64'd1 << FRAC_BITS) + 31, 64'd63));
    end
    return t;
  endfunction

  localparam curve_tbl_t LOG_TBL = build_tbl(1'b1);
  localparam curve_tbl_t EXP_TBL = build_tbl(1'b0);
  localparam sm_tbl_t    SM_TBL  = build_sm();

endpackage

// ----- hdl/cvm_div.sv -----
// restoring divider, one quotient bit per cycle
module cvm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cvm_pkg::DVD_W-1:0] dividend,
  input  logic [cvm_pkg::RAW_W-1:0] divisor,
  output logic                      done,
  output logic [cvm_pkg::DVD_W-1:0] quotient
);
  import cvm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [RAW_W:0]   rem;
  logic [DVD_W-1:0] shreg;
  logic [RAW_W-1:0] dsor;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [RAW_W+1:0] trial;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, shreg[DVD_W-1]} - {2'b0, dsor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend and quotient share the shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dsor  <= divisor;
    end else if (busy) begin
      if (!trial[RAW_W+1]) begin
        rem <= trial[RAW_W:0];
      end else begin
        rem <= {rem[RAW_W-1:0], shreg[DVD_W-1]};
      end
      shreg <= {shreg[DVD_W-2:0], ~trial[RAW_W+1]};
    end
  end

  assign quotient = shreg;

endmodule

// ----- hdl/cvm_mul.sv -----
// shared signed multiplier with registered product
module cvm_mul (
  input  logic                              clk,
  input  logic signed [cvm_pkg::MUL_A_W-1:0] a,
  input  logic signed [cvm_pkg::MUL_B_W-1:0] b,
  output logic signed [cvm_pkg::PROD_W-1:0]  prod
);
  import cvm_pkg::*;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- hdl/controller_value_mapper_core.sv -----
// top level of the controller value mapper: sequencer, registers, curve datapath
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, raw_value             | item in
//  out     | out_valid, out_stall, is_absolute, mapped | result out
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// relative modes skip to ST_OUT; toggle and undefined modes run the curve states;
// absolute mode runs the 30-step divider first; curves use the shared multiplier.
// reset is synchronous; it clears registers to their defaults and the toggle state.
// in_stall is high while an item is at work; the output register frees the
// sequencer so a new item can start while a result waits under out_stall.
module controller_value_mapper_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cvm_pkg::RAW_W-1:0]        raw_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_absolute,
  output logic signed [cvm_pkg::VAL_W-1:0] mapped_value,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [cvm_pkg::CFG_W-1:0]        cfg_data
);
  import cvm_pkg::*;

  cvm_state_t state, state_next;

  logic [2:0]              binding_mode;
  logic [1:0]              curve_shape;
  logic [RAW_W-1:0]        raw_full_scale;
  logic signed [VAL_W-1:0] range_low;
  logic signed [VAL_W-1:0] range_high;
  logic                    toggle_was_high;
  logic                    toggle_on;

  logic [X_W-1:0]          x;
  logic [X_W-1:0]          a_reg;
  logic [X_W-1:0]          c;
  logic signed [VAL_W-1:0] val;
  logic                    abs_flag;

  logic                    accept;
  logic                    out_free;
  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        quot;
  logic [RAW_W-1:0]        divisor;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [IDX_W-1:0]        tbl_idx;
  logic [IDX_W:0]          tbl_idx1;
  logic [X_W-1:0]          tbl_a;
  logic [X_W-1:0]          tbl_b;
  logic [FRAC_BITS-1:0]    frac;
  logic [X_W-1:0]          smooth_t;
  logic [PROD_W-1:0]       prod_adj;
  logic signed [MUL_A_W-1:0] scaled;
  logic signed [MUL_A_W-1:0] range_sum;
  logic                    high_now;
  logic                    toggle_on_next;
  logic [6:0]              v7;
  logic signed [VAL_W-1:0] rel_delta;
  logic [X_W-1:0]          sm_mag;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign divisor  = (raw_full_scale == '0) ? DEFAULT_SCALE : raw_full_scale;

  cvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({raw_value, FRAC_BITS'(0)}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  cvm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      binding_mode   <= MODE_ABS;
      curve_shape    <= CURVE_LIN;
      raw_full_scale <= DEFAULT_SCALE;
      range_low      <= '0;
      range_high     <= VAL_W'(ONE_X);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  binding_mode   <= cfg_data[2:0];
        REG_CURVE: curve_shape    <= cfg_data[1:0];
        REG_SCALE: raw_full_scale <= cfg_data[RAW_W-1:0];
        REG_LOW:   range_low      <= cfg_data[VAL_W-1:0];
        REG_HIGH:  range_high     <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // toggle edge detect and relative step decode
  always_comb begin
    high_now       = |raw_value[RAW_W-1:6];
    toggle_on_next = toggle_on ^ (high_now & ~toggle_was_high);
    v7             = raw_value[6:0];
    sm_mag         = SM_TBL[v7[5:0]];
    case (binding_mode)
      MODE_TWOS:    rel_delta = VAL_W'($signed(v7)) <<< 10;
      MODE_OFFSET:  rel_delta = VAL_W'($signed({~v7[6], v7[5:0]})) <<< 10;
      default: begin
        rel_delta = v7[6] ? -$signed({{(VAL_W-X_W){1'b0}}, sm_mag})
                          :  $signed({{(VAL_W-X_W){1'b0}}, sm_mag});
      end
    endcase
  end

  // curve table reads
  always_comb begin
    tbl_idx  = x[FRAC_BITS-1 -: IDX_W];
    tbl_idx1 = {1'b0, tbl_idx} + 1'b1;
    frac     = FRAC_BITS'({x[FRAC_BITS-IDX_W-1:0], IDX_W'(0)});
    if (curve_shape == CURVE_LOG) begin
      tbl_a = x[FRAC_BITS] ? LOG_TBL[TBL_N] : LOG_TBL[tbl_idx];
      tbl_b = LOG_TBL[tbl_idx1];
    end else begin
      tbl_a = x[FRAC_BITS] ? EXP_TBL[TBL_N] : EXP_TBL[tbl_idx];
      tbl_b = EXP_TBL[tbl_idx1];
    end
  end

  // product slices
  always_comb begin
    smooth_t  = prod[FRAC_BITS +: X_W];
    prod_adj  = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
    scaled    = prod_adj[FRAC_BITS +: MUL_A_W];
    range_sum = MUL_A_W'(range_low) + scaled;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (binding_mode)
            MODE_ABS:                            state_next = ST_DIV;
            MODE_TWOS, MODE_SIGNMAG, MODE_OFFSET: state_next = ST_OUT;
            default:                             state_next = ST_SH1;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_next = ST_SH1;
      ST_SH1:  state_next = (curve_shape == CURVE_LIN) ? ST_RG1 : ST_SH2;
      ST_SH2:  state_next = (curve_shape == CURVE_SMOOTH) ? ST_SH3 : ST_RG1;
      ST_SH3:  state_next = ST_RG1;
      ST_RG1:  state_next = ST_RG2;
      ST_RG2:  state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE: div_start = accept && (binding_mode == MODE_ABS);
      ST_SH1: begin
        if (curve_shape == CURVE_SMOOTH) begin
          mul_a = MUL_A_W'(x);
          mul_b = MUL_B_W'(x);
        end else begin
          mul_a = MUL_A_W'($signed({1'b0, tbl_b}) - $signed({1'b0, tbl_a}));
          mul_b = MUL_B_W'(frac);
        end
      end
      ST_SH2: begin
        mul_a = MUL_A_W'(smooth_t);
        mul_b = MUL_B_W'(3 * (1 << FRAC_BITS)) - MUL_B_W'({x, 1'b0});
      end
      ST_RG1: begin
        mul_a = MUL_A_W'(range_high) - MUL_A_W'(range_low);
        mul_b = MUL_B_W'(c);
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          abs_flag <= 1'b1;
          x        <= '0;
          case (binding_mode)
            MODE_TWOS, MODE_SIGNMAG, MODE_OFFSET: begin
              abs_flag <= 1'b0;
              val      <= rel_delta;
            end
            MODE_TOGGLE: x <= toggle_on_next ? ONE_X : '0;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          x <= (quot > DVD_W'(ONE_X)) ? ONE_X : quot[X_W-1:0];
        end
      end
      ST_SH1: begin
        c     <= x;
        a_reg <= tbl_a;
      end
      ST_SH2: c <= a_reg + smooth_t;
      ST_SH3: c <= smooth_t;
      ST_RG2: val <= range_sum[VAL_W-1:0];
      default: ;
    endcase
  end

  // toggle state changes only in toggle mode
  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_was_high <= 1'b0;
      toggle_on       <= 1'b0;
    end else if (state == ST_IDLE && accept && binding_mode == MODE_TOGGLE) begin
      toggle_was_high <= high_now;
      toggle_on       <= toggle_on_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      is_absolute  <= abs_flag;
      mapped_value <= val;
    end
  end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the controller value mapper core
module testbench;
  import cvm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RAW_W-1:0] raw_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_absolute;
  logic signed [VAL_W-1:0] mapped_value;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic abs_flag;
    logic signed [VAL_W-1:0] value;
  } mapping_t;

  controller_value_mapper_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .raw_value(raw_value), .out_valid(out_valid), .out_stall(out_stall),
    .is_absolute(is_absolute), .mapped_value(mapped_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // own copies of curve tables, built by the same integer series
  longint unsigned log_curve [0:256];
  longint unsigned exp_curve [0:256];

  // predictor state and register mirror
  logic [2:0] mode_reg = MODE_ABS;
  logic [1:0] curve_reg = CURVE_LIN;
  logic [13:0] scale_reg = 14'd127;
  logic [23:0] low_reg = 24'd0;
  logic [23:0] high_reg = 24'd65536;
  bit was_high = 0;
  bit flag_on = 0;

  logic [RAW_W-1:0] raw_queue [$];
  mapping_t expected_maps [$];
  int fail_count = 0;
  int sender_idle = 15;
  int receiver_idle = 69;
  bit hold_off = 0;
  longint cycle_count = 0;

  function automatic longint unsigned round_frac(longint unsigned q);
    longint unsigned r;
    r = (q * 65536 + (64'd1 << 29)) >> 30;
    return (r > 65536) ? 65536 : r;
  endfunction

  task automatic build_curves();
    longint unsigned u, term, sum, z, w, w2, p, s, one30, em1;
    one30 = 64'd1 << 30;
    em1 = 64'd1844991065;
    for (int i = 0; i <= 256; i++) begin
      u = (longint'(i) << 30) / 256;
      term = one30;
      sum = one30;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * u) >> 30) / longint'(k);
        sum += term;
      end
      exp_curve[i] = round_frac(((sum - one30) << 30) / em1);
      z = one30 + ((u * em1) >> 30);
      w = ((z - one30) << 30) / (z + one30);
      w2 = (w * w) >> 30;
      p = w;
      s = 0;
      for (int k = 0; k < 40; k++) begin
        s += p / longint'(2 * k + 1);
        p = (p * w2) >> 30;
      end
      log_curve[i] = round_frac(2 * s);
    end
  endtask

  function automatic longint interp(bit use_log, longint x);
    longint pos, idx, frac, a, b;
    pos = x * 256;
    idx = pos >>> 16;
    frac = pos & 65535;
    if (idx >= 256) return use_log ? log_curve[256] : exp_curve[256];
    a = use_log ? log_curve[idx] : exp_curve[idx];
    b = use_log ? log_curve[idx+1] : exp_curve[idx+1];
    return a + ((b - a) * frac) / 65536;
  endfunction

  function automatic longint shaped(longint x);
    longint t;
    if (x > 65536) x = 65536;
    case (curve_reg)
      CURVE_LOG: return interp(1, x);
      CURVE_EXP: return interp(0, x);
      CURVE_SMOOTH: begin
        t = (x * x) >>> 16;
        return (t * (3 * 65536 - 2 * x)) >>> 16;
      end
      default: return x;
    endcase
  endfunction

  function automatic longint ranged(longint x);
    longint lo, hi;
    lo = longint'($signed(low_reg));
    hi = longint'($signed(high_reg));
    return lo + ((hi - lo) * shaped(x)) / 65536;
  endfunction

  // expected mapping for one raw value; advances toggle state
  function automatic mapping_t map_raw(logic [RAW_W-1:0] raw);
    mapping_t m;
    longint v7, full, y, d;
    bit hi;
    v7 = raw & 7'h7F;
    m.abs_flag = 1'b1;
    case (mode_reg)
      MODE_ABS: begin
        full = (scale_reg == 0) ? 127 : scale_reg;
        y = (longint'(raw) * 65536) / full;
        if (y > 65536) y = 65536;
        d = ranged(y);
      end
      MODE_TWOS: begin
        d = ((v7 < 64) ? v7 : v7 - 128) * 65536 / 64;
        m.abs_flag = 1'b0;
      end
      MODE_SIGNMAG: begin
        d = ((v7 & 6'h3F) * 65536 + 31) / 63;
        if (v7 & 8'h40) d = -d;
        m.abs_flag = 1'b0;
      end
      MODE_OFFSET: begin
        d = (v7 - 64) * 65536 / 64;
        m.abs_flag = 1'b0;
      end
      MODE_TOGGLE: begin
        hi = raw >= 64;
        if (hi && !was_high) flag_on = !flag_on;
        was_high = hi;
        d = ranged(flag_on ? 65536 : 0);
      end
      default: d = ranged(0);
    endcase
    m.value = d[23:0];
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // driver: offers queued items, predicts at acceptance
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_maps.push_back(map_raw(raw_value));
        void'(raw_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (raw_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
          in_valid <= 1'b1;
          raw_value <= raw_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < receiver_idle);
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("unexpected result", mapped_value, 0);
      end else begin
        if (is_absolute !== expected_maps[0].abs_flag)
          report_mismatch("is_absolute", is_absolute, expected_maps[0].abs_flag);
        if (mapped_value !== expected_maps[0].value)
          report_mismatch("mapped_value", mapped_value, expected_maps[0].value);
        void'(expected_maps.pop_front());
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_count > 900000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (raw_queue.size() != 0 || in_valid || expected_maps.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: mode_reg = data[2:0];
      REG_CURVE: curve_reg = data[1:0];
      REG_SCALE: scale_reg = data[13:0];
      REG_LOW: low_reg = data[23:0];
      default: high_reg = data[23:0];
    endcase
  endtask

  task automatic random_setting();
    write_reg(REG_MODE, CFG_W'($urandom_range(99) < 8 ? $urandom_range(7, 5)
                                                      : $urandom_range(4)));
    write_reg(REG_CURVE, CFG_W'($urandom_range(3)));
    case ($urandom_range(3))
      0: write_reg(REG_SCALE, CFG_W'(0));
      1: write_reg(REG_SCALE, CFG_W'(16383));
      default: write_reg(REG_SCALE, CFG_W'($urandom_range(16383)));
    endcase
    case ($urandom_range(3))
      0: begin write_reg(REG_LOW, 24'h800000); write_reg(REG_HIGH, 24'h7FFFFF); end
      1: begin write_reg(REG_LOW, 24'h7FFFFF); write_reg(REG_HIGH, 24'h800000); end
      default: begin
        write_reg(REG_LOW, CFG_W'($urandom()));
        write_reg(REG_HIGH, CFG_W'($urandom()));
      end
    endcase
  endtask

  // raw values biased to toggle crossings and field extremes
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(5))
      0: return RAW_W'($urandom_range(127));
      1: return RAW_W'($urandom_range(70, 58));
      2: return $urandom_range(1) ? 14'h3FFF : 14'h0;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  initial begin
    build_curves();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then each mode and curve at field extremes
    foreach (raw_queue[i]) ;
    raw_queue = '{0, 127, 63, 64, 16383};
    wait_drained();
    for (int md = 0; md < 8; md++) begin
      write_reg(REG_MODE, CFG_W'(md));
      write_reg(REG_CURVE, CFG_W'(md & 3));
      write_reg(REG_SCALE, (md == 0) ? CFG_W'(0) : CFG_W'(16383));
      write_reg(REG_LOW, (md & 1) ? 24'h800000 : 24'h7FFFFF);
      write_reg(REG_HIGH, (md & 1) ? 24'h7FFFFF : 24'h800000);
      raw_queue = '{0, 64, 63, 127, 8191};
      wait_drained();
    end

    // random phases with changing idling
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 10) begin sender_idle = 69; receiver_idle = 15; end
      if (ph == 20) begin sender_idle = 0; receiver_idle = 0; end
      random_setting();
      for (int n = 0; n < 28; n++) raw_queue.push_back(pick_raw());
      if (ph == 25) begin
        // long receiver hold-off while items keep coming
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/cvm_pkg.sv
hdl/cvm_div.sv
hdl/cvm_mul.sv
hdl/controller_value_mapper_core.sv
verif/testbench.sv
